// ===== rtl/slbc_pkg.sv =====
// Shared constants and types for the status LED blink code block.
package slbc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_LONG_PERIOD  = 2'd0;
  localparam logic [1:0] REG_SHORT_PERIOD = 2'd1;
  localparam logic [1:0] REG_PAUSE_STEPS  = 2'd2;

  localparam int unsigned CfgAddrWidth = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned PeriodWidth  = 16;
  localparam int unsigned PauseWidth   = 8;
  localparam int unsigned DiffWidth    = 11;
  localparam int unsigned MagWidth     = 11;
  // 2 * (magnitude + pause) never exceeds 2558
  localparam int unsigned LimitWidth   = 12;
  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned OutDataWidth = 8;

  localparam logic [PeriodWidth-1:0] LongPeriodRst  = 16'd150;
  localparam logic [PeriodWidth-1:0] ShortPeriodRst = 16'd50;
  localparam logic [PauseWidth-1:0]  PauseStepsRst  = 8'd5;

  typedef struct packed {
    logic signed [DiffWidth-1:0] temp_diff;
    logic                        heating_off;
  } item_t;

endpackage

// ===== rtl/status_led_blink_code.sv =====
// Status LED blink code: one tick per item, input register, step logic, result register.
// An accepted item is held in the input register, then the LED level that its step
// gives is taken into the result register.
// Throughput: one item per cycle while m_axis_tready is high; the input register refills in the cycle the
// result register is taken, so both sides run back to back.
// Reset (rst_ni low, asynchronous): timer, step counter and LED cleared, pipeline
// emptied, registers back to long 150, short 50, pause 5.
module status_led_blink_code #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [10:0] temp_diff, [15:11] zero
  input  logic [slbc_pkg::InDataWidth-1:0]    s_axis_tdata,
  // [0] heating_off
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] led_on, [7:1] zero
  output logic [slbc_pkg::OutDataWidth-1:0]   m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [slbc_pkg::CfgAddrWidth-1:0]   cfg_addr_i,
  input  logic [slbc_pkg::CfgDataWidth-1:0]   cfg_wdata_i
);

  localparam int unsigned PW   = (TIMER_WIDTH > slbc_pkg::PeriodWidth) ?
                                 TIMER_WIDTH : slbc_pkg::PeriodWidth;
  localparam int unsigned CMPW = (COUNT_WIDTH > slbc_pkg::LimitWidth) ?
                                 COUNT_WIDTH : slbc_pkg::LimitWidth;

  // configuration
  logic [slbc_pkg::PeriodWidth-1:0] long_period_q, short_period_q;
  logic [slbc_pkg::PauseWidth-1:0]  pause_steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_period_q  <= slbc_pkg::LongPeriodRst;
      short_period_q <= slbc_pkg::ShortPeriodRst;
      pause_steps_q  <= slbc_pkg::PauseStepsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        slbc_pkg::REG_LONG_PERIOD:  long_period_q  <= cfg_wdata_i;
        slbc_pkg::REG_SHORT_PERIOD: short_period_q <= cfg_wdata_i;
        slbc_pkg::REG_PAUSE_STEPS:  pause_steps_q  <= cfg_wdata_i[slbc_pkg::PauseWidth-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            in_valid_q, out_valid_q;
  slbc_pkg::item_t in_item_q;
  logic            adv;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.temp_diff   <= s_axis_tdata[slbc_pkg::DiffWidth-1:0];
      in_item_q.heating_off <= s_axis_tuser;
    end
  end

  // step logic
  logic [TIMER_WIDTH-1:0]          elapsed_q, elapsed_d, elapsed_inc;
  logic [COUNT_WIDTH-1:0]          count_q, count_d, count_inc;
  logic                            led_q, led_d;
  logic [slbc_pkg::MagWidth-1:0]   mag;
  logic                            big, rest, step, neg;
  logic [slbc_pkg::PeriodWidth-1:0] period;
  logic [slbc_pkg::LimitWidth-1:0] twice_mag, limit;
  logic [CMPW-1:0]                 count_ext;
  logic                            below_wink, within_pause, step_led;

  always_comb begin
    mag = in_item_q.temp_diff[slbc_pkg::DiffWidth-1] ?
          slbc_pkg::MagWidth'(-in_item_q.temp_diff) : slbc_pkg::MagWidth'(in_item_q.temp_diff);
    // -1024 negates to itself; its bit pattern is still 1024 unsigned
    big    = (mag > slbc_pkg::MagWidth'(1));
    rest   = big && !in_item_q.temp_diff[slbc_pkg::DiffWidth-1];
    period = big ? long_period_q : short_period_q;

    elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TIMER_WIDTH'(1);
    step        = (PW'(elapsed_inc) > PW'(period));

    count_inc = count_q + COUNT_WIDTH'(1);
    neg       = count_inc[COUNT_WIDTH-1];
    count_ext = CMPW'(count_inc);
    twice_mag = {mag, 1'b0};
    limit     = {slbc_pkg::LimitWidth'(mag) + slbc_pkg::LimitWidth'(pause_steps_q)}
                << 1;
    below_wink   = neg || (count_ext < CMPW'(twice_mag));
    within_pause = neg || (count_ext <= CMPW'(limit));

    count_d = count_inc;
    if (big) begin
      if (below_wink) step_led = count_inc[0] ? !rest : rest;
      else begin
        step_led = rest;
        if (!within_pause) count_d = '0;
      end
    end else begin
      step_led = count_inc[0];
    end
    if (in_item_q.heating_off) step_led = 1'b0;

    elapsed_d = elapsed_inc;
    led_d     = led_q;
    if (step) begin
      elapsed_d = '0;
      led_d     = step_led;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      count_q   <= '0;
      led_q     <= 1'b0;
    end else if (adv) begin
      elapsed_q <= elapsed_d;
      count_q   <= count_d;
      led_q     <= led_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(slbc_pkg::OutDataWidth-1){1'b0}}, led_q};

  // checks
  a_led_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && step) |=> $stable(led_q))
    else $error("LED changed without a step");

  a_heating_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && step && in_item_q.heating_off) |=> !led_q)
    else $error("LED lit after a step with heating off");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
    else $error("accepted item lost from input register");

  a_step_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && step) |=> (elapsed_q == '0))
    else $error("timer not cleared on step");

endmodule
